// File: hw/rtl/gmp_pkg.sv
// ----------------------------------------------------------------------------
// gmp_pkg
// Shared types and codes for the randomized Prim maze generator.
// ----------------------------------------------------------------------------
`default_nettype none

package gmp_pkg;

    localparam logic [6:0] WEIGHT_MAX = 7'd99;

    // Result kinds
    localparam logic [2:0] KIND_PUSH    = 3'd0;
    localparam logic [2:0] KIND_CARVE   = 3'd1;
    localparam logic [2:0] KIND_DISCARD = 3'd2;
    localparam logic [2:0] KIND_DONE    = 3'd3;
    localparam logic [2:0] KIND_RESTART = 3'd4;

    // Wall sides
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;

    localparam logic [4:0] ROWS_RESET = 5'd10;
    localparam logic [4:0] COLS_RESET = 5'd10;

    typedef struct packed {
        logic       func;
        logic [6:0] weight;
    } gmp_in_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] cell_row;
        logic [3:0] cell_col;
        logic [1:0] direction;
        logic [6:0] edge_weight;
    } gmp_out_t;

endpackage

`default_nettype wire

// File: hw/rtl/gmp_ram.sv
// ----------------------------------------------------------------------------
// gmp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hw/rtl/grid_maze_prim_generator_core.sv
// ----------------------------------------------------------------------------
// grid_maze_prim_generator_core
// Randomized Prim maze generator: visited map and edge min-heap in RAM,
// walked by one sequencer around a single key comparator.
// ----------------------------------------------------------------------------
// Each item: a restart is reported, then the visited map is cleared; otherwise the
// pending cell's sides are scanned and the first in-grid unvisited neighbor is pushed
// and sifted up the edge heap (512 entries by default); once the scan is spent, the
// top is popped, sifted down and carved or discarded, or done is reported if empty.
// One item at a time, busy high until done. Reset and restart clear the visited map
// one entry a cycle (2^(rowbits+colbits), 256 entries by default). The receiver cannot stall.
`default_nettype none

module grid_maze_prim_generator_core #(
    parameter int MAX_ROWS   = 16,
    parameter int MAX_COLS   = 16,
    parameter int HEAP_DEPTH = 512
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire gmp_pkg::gmp_in_t cmd,
    output logic                  result_valid,
    output gmp_pkg::gmp_out_t     result,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [4:0]       cfg_data
);

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int AW    = $clog2(MAX_ROWS + 1);
    localparam int CAW   = $clog2(MAX_COLS + 1);
    localparam int VAW   = RW + CW;
    localparam int VDEPTH = 1 << VAW;
    localparam int HIW   = $clog2(HEAP_DEPTH);
    localparam int HCW   = $clog2(HEAP_DEPTH + 1);
    localparam int LW    = HCW + 2;

    typedef struct packed {
        logic [6:0]    w;
        logic [RW-1:0] r;
        logic [CW-1:0] c;
        logic [1:0]    d;
    } edge_t;

    localparam int EW = $bits(edge_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN,
        ST_SCAN_CHK,
        ST_PUSH_UP,
        ST_PUSH_CMP,
        ST_POP_TOP,
        ST_POP_LAST,
        ST_POP_L,
        ST_POP_LD,
        ST_POP_RD,
        ST_POP_MOVE,
        ST_CARVE,
        ST_CARVE_CHK
    } state_t;

    state_t             state_reg, state_next;
    logic [4:0]         grid_rows_reg, grid_rows_next;
    logic [4:0]         grid_cols_reg, grid_cols_next;
    logic [AW-1:0]      act_rows_reg, act_rows_next;
    logic [CAW-1:0]     act_cols_reg, act_cols_next;
    logic [HCW-1:0]     count_reg, count_next;
    logic [RW-1:0]      prow_reg, prow_next;
    logic [CW-1:0]      pcol_reg, pcol_next;
    logic [2:0]         pdir_reg, pdir_next;
    logic               pushing_reg, pushing_next;
    logic [6:0]         weight_reg, weight_next;
    edge_t              elem_reg, elem_next;
    edge_t              top_reg, top_next;
    edge_t              bestv_reg, bestv_next;
    logic [HIW-1:0]     best_idx_reg, best_idx_next;
    logic               best_child_reg, best_child_next;
    logic [HIW-1:0]     idx_reg, idx_next;
    logic [VAW-1:0]     clr_reg, clr_next;
    logic               res_valid_reg, res_valid_next;
    gmp_pkg::gmp_out_t  res_reg, res_next;

    // RAM ports
    logic               heap_we, heap_re;
    logic [HIW-1:0]     heap_waddr, heap_raddr;
    logic [EW-1:0]      heap_wdata, heap_rdata;
    edge_t              heap_rd;
    logic               vis_we, vis_re;
    logic [VAW-1:0]     vis_waddr, vis_raddr;
    logic [0:0]         vis_wdata, vis_rdata;

    // Shared neighbor unit and comparator
    logic [RW-1:0]      nb_r, nb_row;
    logic [CW-1:0]      nb_c, nb_col;
    logic [1:0]         nb_d;
    logic               nb_in;
    edge_t              cmp_a, cmp_b;
    logic               cmp_less;

    logic [LW-1:0]      left_ix, right_ix, count_ext;
    logic [HIW-1:0]     parent_ix;
    edge_t              push_e;
    logic [7:0]         rows8, cols8;

    gmp_ram #(.WIDTH(EW), .DEPTH(HEAP_DEPTH)) u_heap (
        .clk   (clk),
        .we    (heap_we),
        .waddr (heap_waddr),
        .wdata (heap_wdata),
        .re    (heap_re),
        .raddr (heap_raddr),
        .rdata (heap_rdata)
    );

    gmp_ram #(.WIDTH(1), .DEPTH(VDEPTH)) u_visited (
        .clk   (clk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .re    (vis_re),
        .raddr (vis_raddr),
        .rdata (vis_rdata)
    );

    assign heap_rd = edge_t'(heap_rdata);

    // Neighbor of the popped edge while carving, of the pending cell otherwise
    always_comb
    begin
        if (state_reg == ST_CARVE || state_reg == ST_CARVE_CHK)
        begin
            nb_r = top_reg.r;
            nb_c = top_reg.c;
            nb_d = top_reg.d;
        end
        else
        begin
            nb_r = prow_reg;
            nb_c = pcol_reg;
            nb_d = pdir_reg[1:0];
        end
        nb_row = nb_r;
        nb_col = nb_c;
        case (nb_d)
            gmp_pkg::DIR_UP:
            begin
                nb_in  = (nb_r != '0);
                nb_row = nb_r - RW'(1);
            end
            gmp_pkg::DIR_RIGHT:
            begin
                nb_in  = ((CAW'(nb_c) + CAW'(1)) < act_cols_reg);
                nb_col = nb_c + CW'(1);
            end
            gmp_pkg::DIR_DOWN:
            begin
                nb_in  = ((AW'(nb_r) + AW'(1)) < act_rows_reg);
                nb_row = nb_r + RW'(1);
            end
            gmp_pkg::DIR_LEFT:
            begin
                nb_in  = (nb_c != '0);
                nb_col = nb_c - CW'(1);
            end
            default:
            begin
                nb_in = 1'b0;
            end
        endcase
    end

    // Key compare: weight, row, column, direction packed most significant first
    always_comb
    begin
        case (state_reg)
            ST_PUSH_CMP:
            begin
                cmp_a = elem_reg;
                cmp_b = heap_rd;
            end
            ST_POP_LD:
            begin
                cmp_a = heap_rd;
                cmp_b = elem_reg;
            end
            default:
            begin
                cmp_a = heap_rd;
                cmp_b = bestv_reg;
            end
        endcase
    end

    assign cmp_less  = (cmp_a < cmp_b);
    assign left_ix   = LW'({idx_reg, 1'b1});
    assign right_ix  = left_ix + LW'(1);
    assign count_ext = LW'(count_reg);
    assign parent_ix = (idx_reg - HIW'(1)) >> 1;
    assign rows8     = 8'(grid_rows_reg);
    assign cols8     = 8'(grid_cols_reg);

    always_comb
    begin
        push_e.w = weight_reg;
        push_e.r = prow_reg;
        push_e.c = pcol_reg;
        push_e.d = pdir_reg[1:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        grid_rows_next  = grid_rows_reg;
        grid_cols_next  = grid_cols_reg;
        act_rows_next   = act_rows_reg;
        act_cols_next   = act_cols_reg;
        count_next      = count_reg;
        prow_next       = prow_reg;
        pcol_next       = pcol_reg;
        pdir_next       = pdir_reg;
        pushing_next    = pushing_reg;
        weight_next     = weight_reg;
        elem_next       = elem_reg;
        top_next        = top_reg;
        bestv_next      = bestv_reg;
        best_idx_next   = best_idx_reg;
        best_child_next = best_child_reg;
        idx_next        = idx_reg;
        clr_next        = clr_reg;
        res_valid_next  = 1'b0;
        res_next        = res_reg;

        heap_we    = 1'b0;
        heap_waddr = idx_reg;
        heap_wdata = elem_reg;
        heap_re    = 1'b0;
        heap_raddr = '0;
        vis_we     = 1'b0;
        vis_waddr  = {nb_row, nb_col};
        vis_wdata  = 1'b1;
        vis_re     = 1'b0;
        vis_raddr  = {nb_row, nb_col};

        if (cfg_valid)
        begin
            case (cfg_index)
                gmp_pkg::REG_ROWS: grid_rows_next = cfg_data;
                gmp_pkg::REG_COLS: grid_cols_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    weight_next = (cmd.weight > gmp_pkg::WEIGHT_MAX) ?
                                  gmp_pkg::WEIGHT_MAX : cmd.weight;
                    if (cmd.func)
                    begin
                        if (grid_rows_reg == '0)
                            act_rows_next = AW'(1);
                        else if (rows8 > 8'(MAX_ROWS))
                            act_rows_next = AW'(MAX_ROWS);
                        else
                            act_rows_next = AW'(grid_rows_reg);
                        if (grid_cols_reg == '0)
                            act_cols_next = CAW'(1);
                        else if (cols8 > 8'(MAX_COLS))
                            act_cols_next = CAW'(MAX_COLS);
                        else
                            act_cols_next = CAW'(grid_cols_reg);
                        count_next     = '0;
                        prow_next      = '0;
                        pcol_next      = '0;
                        pdir_next      = '0;
                        pushing_next   = 1'b1;
                        clr_next       = '0;
                        res_valid_next = 1'b1;
                        res_next       = '0;
                        res_next.kind  = gmp_pkg::KIND_RESTART;
                        state_next     = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_CLEAR:
            begin
                // Only cell (0,0) comes out visited
                vis_we    = 1'b1;
                vis_waddr = clr_reg;
                vis_wdata = (clr_reg == '0);
                clr_next  = clr_reg + VAW'(1);
                if (clr_reg == VAW'(VDEPTH - 1))
                    state_next = ST_IDLE;
            end

            ST_SCAN:
            begin
                if (pushing_reg && pdir_reg < 3'd4)
                begin
                    if (nb_in)
                    begin
                        vis_re     = 1'b1;
                        state_next = ST_SCAN_CHK;
                    end
                    else
                    begin
                        pdir_next = pdir_reg + 3'd1;
                    end
                end
                else
                begin
                    pushing_next = 1'b0;
                    if (count_reg == '0)
                    begin
                        res_valid_next = 1'b1;
                        res_next       = '0;
                        res_next.kind  = gmp_pkg::KIND_DONE;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        heap_re    = 1'b1;
                        heap_raddr = '0;
                        state_next = ST_POP_TOP;
                    end
                end
            end

            ST_SCAN_CHK:
            begin
                pdir_next = pdir_reg + 3'd1;
                if (vis_rdata[0])
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    res_next.kind        = gmp_pkg::KIND_PUSH;
                    res_next.cell_row    = 4'(push_e.r);
                    res_next.cell_col    = 4'(push_e.c);
                    res_next.direction   = push_e.d;
                    res_next.edge_weight = push_e.w;
                    elem_next            = push_e;
                    if (count_reg == HCW'(HEAP_DEPTH))
                    begin
                        // Full heap: drop the edge, still report it
                        res_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = HIW'(count_reg);
                        count_next = count_reg + HCW'(1);
                        state_next = ST_PUSH_UP;
                    end
                end
            end

            ST_PUSH_UP:
            begin
                if (idx_reg == '0)
                begin
                    heap_we        = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    heap_re    = 1'b1;
                    heap_raddr = parent_ix;
                    state_next = ST_PUSH_CMP;
                end
            end

            ST_PUSH_CMP:
            begin
                heap_we = 1'b1;
                if (cmp_less)
                begin
                    // Move the parent down into the hole
                    heap_wdata = heap_rdata;
                    idx_next   = parent_ix;
                    state_next = ST_PUSH_UP;
                end
                else
                begin
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_POP_TOP:
            begin
                top_next   = heap_rd;
                heap_re    = 1'b1;
                heap_raddr = HIW'(count_reg - HCW'(1));
                count_next = count_reg - HCW'(1);
                state_next = ST_POP_LAST;
            end

            ST_POP_LAST:
            begin
                elem_next  = heap_rd;
                idx_next   = '0;
                state_next = ST_POP_L;
            end

            ST_POP_L:
            begin
                if (left_ix < count_ext)
                begin
                    heap_re    = 1'b1;
                    heap_raddr = HIW'(left_ix);
                    state_next = ST_POP_LD;
                end
                else
                begin
                    heap_we    = 1'b1;
                    state_next = ST_CARVE;
                end
            end

            ST_POP_LD:
            begin
                if (cmp_less)
                begin
                    bestv_next      = heap_rd;
                    best_idx_next   = HIW'(left_ix);
                    best_child_next = 1'b1;
                end
                else
                begin
                    bestv_next      = elem_reg;
                    best_child_next = 1'b0;
                end
                if (right_ix < count_ext)
                begin
                    heap_re    = 1'b1;
                    heap_raddr = HIW'(right_ix);
                    state_next = ST_POP_RD;
                end
                else
                begin
                    state_next = ST_POP_MOVE;
                end
            end

            ST_POP_RD:
            begin
                if (cmp_less)
                begin
                    bestv_next      = heap_rd;
                    best_idx_next   = HIW'(right_ix);
                    best_child_next = 1'b1;
                end
                state_next = ST_POP_MOVE;
            end

            ST_POP_MOVE:
            begin
                heap_we = 1'b1;
                if (best_child_reg)
                begin
                    // Lift the smaller child, hole moves down
                    heap_wdata = bestv_reg;
                    idx_next   = best_idx_reg;
                    state_next = ST_POP_L;
                end
                else
                begin
                    state_next = ST_CARVE;
                end
            end

            ST_CARVE:
            begin
                res_next.cell_row    = 4'(top_reg.r);
                res_next.cell_col    = 4'(top_reg.c);
                res_next.direction   = top_reg.d;
                res_next.edge_weight = top_reg.w;
                if (nb_in)
                begin
                    vis_re     = 1'b1;
                    state_next = ST_CARVE_CHK;
                end
                else
                begin
                    res_next.kind  = gmp_pkg::KIND_DISCARD;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_CARVE_CHK:
            begin
                res_valid_next = 1'b1;
                state_next     = ST_IDLE;
                if (vis_rdata[0])
                begin
                    res_next.kind = gmp_pkg::KIND_DISCARD;
                end
                else
                begin
                    vis_we        = 1'b1;
                    prow_next     = nb_row;
                    pcol_next     = nb_col;
                    pdir_next     = '0;
                    pushing_next  = 1'b1;
                    res_next.kind = gmp_pkg::KIND_CARVE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            grid_rows_reg  <= gmp_pkg::ROWS_RESET;
            grid_cols_reg  <= gmp_pkg::COLS_RESET;
            act_rows_reg   <= AW'(gmp_pkg::ROWS_RESET);
            act_cols_reg   <= CAW'(gmp_pkg::COLS_RESET);
            count_reg      <= '0;
            prow_reg       <= '0;
            pcol_reg       <= '0;
            pdir_reg       <= '0;
            pushing_reg    <= 1'b1;
            idx_reg        <= '0;
            clr_reg        <= '0;
            best_child_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            grid_rows_reg  <= grid_rows_next;
            grid_cols_reg  <= grid_cols_next;
            act_rows_reg   <= act_rows_next;
            act_cols_reg   <= act_cols_next;
            count_reg      <= count_next;
            prow_reg       <= prow_next;
            pcol_reg       <= pcol_next;
            pdir_reg       <= pdir_next;
            pushing_reg    <= pushing_next;
            idx_reg        <= idx_next;
            clr_reg        <= clr_next;
            best_child_reg <= best_child_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        weight_reg   <= weight_next;
        elem_reg     <= elem_next;
        top_reg      <= top_next;
        bestv_reg    <= bestv_next;
        best_idx_reg <= best_idx_next;
        res_reg      <= res_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;
    assign cfg_ready    = 1'b1;

endmodule

`default_nettype wire

// File: hw/rtl/gmp_chk.sv
// ----------------------------------------------------------------------------
// gmp_chk
// Port-level checks for the maze generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gmp_chk (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire gmp_pkg::gmp_in_t  cmd,
    input wire logic              result_valid,
    input wire gmp_pkg::gmp_out_t result,
    input wire logic              cfg_valid,
    input wire logic              cfg_ready,
    input wire logic [1:0]        cfg_index,
    input wire logic [4:0]        cfg_data
);

    // An accepted item always makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    // Results only come out of work in progress or a restart just accepted
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy || start))
        else $error("result without a preceding busy cycle");

    // One result per item; only a restart taken during a strobe answers next cycle
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !(start && !busy) |=> !result_valid)
        else $error("two results in consecutive cycles");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.kind <= gmp_pkg::KIND_RESTART))
        else $error("result kind out of range");

    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.kind == gmp_pkg::KIND_DONE ||
                         result.kind == gmp_pkg::KIND_RESTART)
        |-> (result.cell_row == '0 && result.cell_col == '0 &&
             result.direction == '0 && result.edge_weight == '0))
        else $error("done or restart result carries nonzero fields");

endmodule

bind grid_maze_prim_generator_core gmp_chk u_gmp_chk (.*);

`default_nettype wire
